// ===== rtl/rra_pkg.sv =====
// shared types and constants for the rotation accumulator
package rra_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CORDIC,
      ST_K2,
      ST_RMAT,
      ST_MMUL,
      ST_COMMIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_row;
      logic start_rot;
      logic cordic_step;
      logic k2_step;
      logic r_step;
      logic m_step;
      logic commit;
      logic out_valid;
   } cmd_type;

   typedef struct packed {
      logic cordic_done;
      logic k2_done;
      logic r_done;
      logic m_done;
   } status_type;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_ROTATE = 1'b1;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
      logic signed [33:0] v;
      case (idx)
         5'd0:  v = 34'sd536870912;
         5'd1:  v = 34'sd316933406;
         5'd2:  v = 34'sd167458907;
         5'd3:  v = 34'sd85004756;
         5'd4:  v = 34'sd42667331;
         5'd5:  v = 34'sd21354465;
         5'd6:  v = 34'sd10679838;
         5'd7:  v = 34'sd5340245;
         5'd8:  v = 34'sd2670163;
         5'd9:  v = 34'sd1335087;
         5'd10: v = 34'sd667544;
         5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;
         5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;
         5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;
         5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;
         5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;
         5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;
         5'd23: v = 34'sd81;
         5'd24: v = 34'sd41;
         5'd25: v = 34'sd20;
         5'd26: v = 34'sd10;
         5'd27: v = 34'sd5;
         5'd28: v = 34'sd3;
         5'd29: v = 34'sd1;
         5'd30: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      logic signed [15:0] r;
      if (v > 48'sd32767) r = 16'sd32767;
      else if (v < -48'sd32768) r = -16'sd32768;
      else r = v[15:0];
      return r;
   endfunction

endpackage

// ===== rtl/rra_ctrl.sv =====
// sequencing state machine for load and rotate items
module rra_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_beat,
   input  logic                in_rotate,
   input  logic                out_beat,
   input  rra_pkg::status_type status,
   output rra_pkg::cmd_type    cmd,
   output logic                busy
);

   rra_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= rra_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rra_pkg::ST_IDLE: begin
            if (in_beat) state_in = in_rotate ? rra_pkg::ST_CORDIC : rra_pkg::ST_OUT;
         end
         rra_pkg::ST_CORDIC: if (status.cordic_done) state_in = rra_pkg::ST_K2;
         rra_pkg::ST_K2:     if (status.k2_done) state_in = rra_pkg::ST_RMAT;
         rra_pkg::ST_RMAT:   if (status.r_done) state_in = rra_pkg::ST_MMUL;
         rra_pkg::ST_MMUL:   if (status.m_done) state_in = rra_pkg::ST_COMMIT;
         rra_pkg::ST_COMMIT: state_in = rra_pkg::ST_OUT;
         rra_pkg::ST_OUT:    if (out_beat) state_in = rra_pkg::ST_IDLE;
         default:            state_in = rra_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         rra_pkg::ST_IDLE: begin
            busy = 1'b0;
            cmd.load_row = in_beat && !in_rotate;
            cmd.start_rot = in_beat && in_rotate;
         end
         rra_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
         rra_pkg::ST_K2:     cmd.k2_step = 1'b1;
         rra_pkg::ST_RMAT:   cmd.r_step = 1'b1;
         rra_pkg::ST_MMUL:   cmd.m_step = 1'b1;
         rra_pkg::ST_COMMIT: cmd.commit = 1'b1;
         rra_pkg::ST_OUT:    cmd.out_valid = 1'b1;
         default:            busy = 1'b1;
      endcase
   end

   a_out_after_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff == rra_pkg::ST_COMMIT |=> state_ff == rra_pkg::ST_OUT)
      else $error("commit not followed by output");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !(cmd.load_row || cmd.start_rot))
      else $error("item taken while busy");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      cmd.out_valid && !out_beat |=> cmd.out_valid)
      else $error("result dropped");

endmodule

// ===== rtl/rra_dp.sv =====
// cordic, shared multiplier and matrix storage
module rra_dp #(
   parameter int FRAC_BITS    = 14,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rra_pkg::cmd_type    cmd,
   input  logic [1:0]          in_row,
   input  logic signed [15:0]  in_x,
   input  logic signed [15:0]  in_y,
   input  logic signed [15:0]  in_z,
   input  logic signed [15:0]  in_angle,
   output rra_pkg::status_type status,
   output logic [143:0]        mat_flat
);

   localparam int NSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
   localparam int SC_SH = 30 - FRAC_BITS;
   localparam logic signed [47:0] ONE = 48'sd1 <<< FRAC_BITS;
   localparam logic signed [47:0] HALF_F = 48'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [33:0] HALF_SC = (SC_SH > 0) ? (34'sd1 <<< (SC_SH - 1)) : 34'sd0;

   logic signed [15:0] mat_ff [9];
   logic signed [15:0] newm_ff [9];
   logic signed [16:0] k_ff [9];
   logic signed [23:0] k2_ff [9];
   logic signed [15:0] r_ff [9];
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic               flip_ff;
   logic [5:0]         step_ff;
   logic signed [33:0] sn_ff, omc_ff;
   logic [1:0]         row_ff, col_ff, t_ff;
   logic [3:0]         ent_ff;
   logic               issued_ff;
   logic signed [47:0] prod_ff, acc_ff;
   logic               pv_ff, pfirst_ff, plast_ff;
   logic [3:0]         pidx_ff;

   logic signed [15:0] ang_adj;
   logic               flip_in;
   logic signed [33:0] ysh, xsh, at;
   logic signed [33:0] cos_x, sin_y;
   logic [3:0]         row_base;
   logic [3:0]         a_idx, b_idx;
   logic signed [33:0] ma;
   logic signed [23:0] mb;
   logic signed [57:0] prod;
   logic signed [47:0] sum, rnd;
   logic               mac_on, issue, t_last, ent_last, fin, diag;

   always_comb begin
      flip_in = 1'b0;
      ang_adj = in_angle;
      if (in_angle >= 16'sd16384) begin
         ang_adj = in_angle - 16'sd32767 - 16'sd1;
         flip_in = 1'b1;
      end else if (in_angle < -16'sd16384) begin
         ang_adj = in_angle + 16'sd32767 + 16'sd1;
         flip_in = 1'b1;
      end
   end

   assign ysh = cy_ff >>> step_ff[4:0];
   assign xsh = cx_ff >>> step_ff[4:0];
   assign at  = rra_pkg::atan_lut(step_ff[4:0]);
   assign cos_x = flip_ff ? -cx_ff : cx_ff;
   assign sin_y = flip_ff ? -cy_ff : cy_ff;

   assign row_base = 4'(in_row) * 4'd3;

   always_comb begin
      a_idx = 4'(row_ff) * 4'd3 + 4'(t_ff);
      b_idx = 4'(t_ff) * 4'd3 + 4'(col_ff);
      ma = '0;
      mb = '0;
      if (cmd.k2_step) begin
         ma = 34'(k_ff[a_idx]);
         mb = 24'(k_ff[b_idx]);
      end else if (cmd.r_step) begin
         ma = (t_ff == 2'd0) ? sn_ff : omc_ff;
         mb = (t_ff == 2'd0) ? 24'(k_ff[ent_ff]) : k2_ff[ent_ff];
      end else if (cmd.m_step) begin
         ma = 34'(r_ff[a_idx]);
         mb = 24'(mat_ff[b_idx]);
      end
   end

   assign prod = ma * mb;
   assign mac_on = cmd.k2_step || cmd.r_step || cmd.m_step;
   assign issue = mac_on && !issued_ff;
   assign t_last = cmd.r_step ? (t_ff == 2'd1) : (t_ff == 2'd2);
   assign ent_last = (ent_ff == 4'd8);
   // products land in the cycle after issue and are summed there
   assign sum = pfirst_ff ? prod_ff : acc_ff + prod_ff;
   assign rnd = (sum + HALF_F) >>> FRAC_BITS;
   assign fin = pv_ff && plast_ff && (pidx_ff == 4'd8);
   assign diag = pidx_ff inside {4'd0, 4'd4, 4'd8};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int e = 0; e < 9; e++)
            mat_ff[e] <= (e == 0 || e == 4 || e == 8) ? rra_pkg::sat16(ONE) : 16'sd0;
         step_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         t_ff <= '0;
         ent_ff <= '0;
         issued_ff <= 1'b0;
         pv_ff <= 1'b0;
         pfirst_ff <= 1'b0;
         plast_ff <= 1'b0;
         pidx_ff <= '0;
      end else begin
         if (cmd.load_row && in_row != 2'd3) begin
            mat_ff[row_base]        <= in_x;
            mat_ff[row_base + 4'd1] <= in_y;
            mat_ff[row_base + 4'd2] <= in_z;
         end
         if (cmd.start_rot) begin
            k_ff[0] <= '0;           k_ff[1] <= -17'(in_z);   k_ff[2] <= 17'(in_y);
            k_ff[3] <= 17'(in_z);    k_ff[4] <= '0;           k_ff[5] <= -17'(in_x);
            k_ff[6] <= -17'(in_y);   k_ff[7] <= 17'(in_x);    k_ff[8] <= '0;
            cx_ff <= rra_pkg::CORDIC_GAIN;
            cy_ff <= '0;
            cz_ff <= 34'(ang_adj) <<< 16;
            flip_ff <= flip_in;
            step_ff <= '0;
         end
         if (cmd.cordic_step) begin
            if (step_ff < 6'(NSTEPS)) begin
               if (!cz_ff[33]) begin
                  cx_ff <= cx_ff - ysh;
                  cy_ff <= cy_ff + xsh;
                  cz_ff <= cz_ff - at;
               end else begin
                  cx_ff <= cx_ff + ysh;
                  cy_ff <= cy_ff - xsh;
                  cz_ff <= cz_ff + at;
               end
               step_ff <= step_ff + 6'd1;
            end else begin
               sn_ff <= (sin_y + HALF_SC) >>> SC_SH;
               omc_ff <= 34'(ONE - 48'((cos_x + HALF_SC) >>> SC_SH));
            end
         end
         if (issue) begin
            if (t_last) begin
               t_ff <= '0;
               if (ent_last) begin
                  row_ff <= '0;
                  col_ff <= '0;
                  ent_ff <= '0;
                  issued_ff <= 1'b1;
               end else begin
                  ent_ff <= ent_ff + 4'd1;
                  if (col_ff == 2'd2) begin
                     col_ff <= '0;
                     row_ff <= row_ff + 2'd1;
                  end else begin
                     col_ff <= col_ff + 2'd1;
                  end
               end
            end else begin
               t_ff <= t_ff + 2'd1;
            end
         end
         pv_ff <= issue;
         pfirst_ff <= (t_ff == 2'd0);
         plast_ff <= t_last;
         pidx_ff <= ent_ff;
         prod_ff <= 48'(prod);
         if (pv_ff) begin
            acc_ff <= sum;
            if (plast_ff) begin
               if (cmd.k2_step) k2_ff[pidx_ff] <= 24'(rnd);
               if (cmd.r_step)  r_ff[pidx_ff] <= rra_pkg::sat16(rnd + (diag ? ONE : 48'sd0));
               if (cmd.m_step)  newm_ff[pidx_ff] <= rra_pkg::sat16(rnd);
            end
         end
         if (fin) issued_ff <= 1'b0;
         if (cmd.commit)
            for (int e = 0; e < 9; e++) mat_ff[e] <= newm_ff[e];
      end
   end

   assign status.cordic_done = cmd.cordic_step && (step_ff == 6'(NSTEPS));
   assign status.k2_done = cmd.k2_step && fin;
   assign status.r_done = cmd.r_step && fin;
   assign status.m_done = cmd.m_step && fin;

   always_comb begin
      for (int e = 0; e < 9; e++) mat_flat[e*16 +: 16] = mat_ff[e];
   end

endmodule

// ===== rtl/rodrigues_rotation_accumulate_top.sv =====
// top level of the rotation accumulator
// A load beat writes the selected row (row 3 writes nothing) and the matrix is
// offered on the next cycle. A rotate beat runs the CORDIC iterations, then K^2,
// R and R*M on one shared multiplier (three products per entry for K^2 and R*M,
// two for R) and a commit, and then the result is offered. One beat is worked on
// at a time: the next beat is taken only once the result has been taken, so a
// result held back by rsp_tready holds off the input.
module rodrigues_rotation_accumulate_top #(
   parameter int FRAC_BITS    = 14,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // comp_x, comp_y, comp_z, angle
   input  logic [63:0]  req_tdata,
   // action, row_select
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22
   output logic [143:0] rsp_tdata
);

   rra_pkg::cmd_type    cmd;
   rra_pkg::status_type status;
   logic busy, in_beat, out_beat;

   assign req_tready = !busy;
   assign in_beat = req_tvalid && req_tready;
   assign out_beat = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = cmd.out_valid;

   rra_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_beat(in_beat),
      .in_rotate(req_tuser[0] == rra_pkg::ACTION_ROTATE),
      .out_beat(out_beat), .status(status), .cmd(cmd), .busy(busy)
   );

   rra_dp #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .in_row(req_tuser[2:1]), .in_x(req_tdata[15:0]), .in_y(req_tdata[31:16]),
      .in_z(req_tdata[47:32]), .in_angle(req_tdata[63:48]),
      .status(status), .mat_flat(rsp_tdata)
   );

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the rotation accumulator: loads, rotations, stalls and gaps
`timescale 1ns / 100ps

module tb_top;

   localparam int FRAC_BITS    = 14;
   localparam int CORDIC_STEPS = 16;
   localparam int RAND_BEATS   = 1600;
   localparam int CYCLE_LIMIT  = 3000000;

   typedef struct {
      logic              action;
      logic [1:0]        row_select;
      logic signed [15:0] comp_x;
      logic signed [15:0] comp_y;
      logic signed [15:0] comp_z;
      logic signed [15:0] angle;
   } rot_beat_type;

   class orient_scoreboard_type;
      longint orient[9];
      logic [143:0] matrix_q[$];
      int mismatches;
      int matched;
      longint atan_step[32] = '{
         536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
         10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
         41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
         10, 5, 3, 1, 1, 0};

      function new();
         longint d;
         d = clamp16(longint'(1) << FRAC_BITS);
         foreach (orient[i]) orient[i] = 0;
         orient[0] = d;
         orient[4] = d;
         orient[8] = d;
         mismatches = 0;
         matched = 0;
      endfunction

      function longint clamp16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint rnd(longint v, int s);
         if (s == 0) return v;
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function void sin_cos(longint a, output longint sn, output longint cs);
         longint x, y, z, nx;
         bit flip;
         x = 652032874;
         y = 0;
         flip = 0;
         if (a >= 16384) begin
            a = a - 32768;
            flip = 1;
         end else if (a < -16384) begin
            a = a + 32768;
            flip = 1;
         end
         z = a * 65536;
         for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y  = y + (x >>> i);
               z  = z - atan_step[i];
            end else begin
               nx = x + (y >>> i);
               y  = y - (x >>> i);
               z  = z + atan_step[i];
            end
            x = nx;
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         cs = rnd(x, 30 - FRAC_BITS);
         sn = rnd(y, 30 - FRAC_BITS);
      endfunction

      function void apply_rotation(longint ax, longint ay, longint az, longint ang);
         longint k[9], k2[9], r[9], m[9];
         longint one, sn, cs, omc, acc;
         one = longint'(1) << FRAC_BITS;
         k = '{0, -az, ay, az, 0, -ax, -ay, ax, 0};
         sin_cos(ang, sn, cs);
         omc = one - cs;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               acc = 0;
               for (int t = 0; t < 3; t++) acc += k[i*3+t] * k[t*3+j];
               k2[i*3+j] = rnd(acc, FRAC_BITS);
            end
         for (int i = 0; i < 9; i++) begin
            acc = rnd(sn * k[i] + omc * k2[i], FRAC_BITS);
            if (i == 0 || i == 4 || i == 8) acc += one;
            r[i] = clamp16(acc);
         end
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               acc = 0;
               for (int t = 0; t < 3; t++) acc += r[i*3+t] * orient[t*3+j];
               m[i*3+j] = clamp16(rnd(acc, FRAC_BITS));
            end
         orient = m;
      endfunction

      function void note_beat(rot_beat_type b);
         logic [143:0] w;
         if (b.action == rra_pkg::ACTION_LOAD) begin
            if (b.row_select < 3) begin
               orient[b.row_select*3]   = b.comp_x;
               orient[b.row_select*3+1] = b.comp_y;
               orient[b.row_select*3+2] = b.comp_z;
            end
         end else begin
            apply_rotation(b.comp_x, b.comp_y, b.comp_z, b.angle);
         end
         for (int i = 0; i < 9; i++) w[i*16 +: 16] = orient[i][15:0];
         matrix_q.push_back(w);
      endfunction

      function void check_matrix(logic [143:0] got);
         logic [143:0] want;
         bit bad;
         if (matrix_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
         end
         want = matrix_q.pop_front();
         bad = 0;
         for (int i = 0; i < 9; i++)
            if (got[i*16 +: 16] !== want[i*16 +: 16]) begin
               bad = 1;
               if (mismatches < 10)
                  $display("m%0d%0d: expected %0d got %0d", i / 3, i % 3,
                           $signed(want[i*16 +: 16]), $signed(got[i*16 +: 16]));
            end
         if (bad) mismatches++;
         else matched++;
      endfunction

      function int pending();
         return matrix_q.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [63:0]  req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;

   orient_scoreboard_type sb;
   int idle_phase;
   int hold_cycles;
   int cycles;
   int n_loads;
   int n_rotates;

   rodrigues_rotation_accumulate_top #(
      .FRAC_BITS   (FRAC_BITS),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // receiver side
   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready = 0;
         end else if (idle_phase == 0) begin
            rsp_tready = ($urandom_range(99) >= 77);
         end else if (idle_phase == 1) begin
            rsp_tready = ($urandom_range(99) >= 9);
         end else begin
            rsp_tready = 1;
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_matrix(rsp_tdata);

   task automatic send_beat(rot_beat_type b);
      int gap_pct;
      gap_pct = (idle_phase == 0) ? 9 : (idle_phase == 1) ? 77 : 0;
      while ($urandom_range(99) < gap_pct) begin
         @(negedge clock);
         req_tvalid = 0;
      end
      @(negedge clock);
      req_tvalid = 1;
      req_tdata  = {b.angle, b.comp_z, b.comp_y, b.comp_x};
      req_tuser  = {b.row_select, b.action};
      do @(posedge clock); while (!req_tready);
      sb.note_beat(b);
      if (b.action == rra_pkg::ACTION_LOAD) n_loads++;
      else n_rotates++;
   endtask

   task automatic load_row(int row, int x, int y, int z);
      rot_beat_type b;
      b = '{rra_pkg::ACTION_LOAD, 2'(row), 16'(x), 16'(y), 16'(z), 16'($urandom)};
      send_beat(b);
   endtask

   task automatic rotate_by(int x, int y, int z, int ang);
      rot_beat_type b;
      b = '{rra_pkg::ACTION_ROTATE, 2'($urandom), 16'(x), 16'(y), 16'(z), 16'(ang)};
      send_beat(b);
   endtask

   task automatic random_beat();
      real ux, uy, uz, nrm;
      int pick;
      pick = $urandom_range(99);
      if (pick < 22) begin
         if ($urandom_range(1))
            load_row($urandom_range(3), $urandom, $urandom, $urandom);
         else
            load_row($urandom_range(2), $urandom_range(32768) - 16384,
                     $urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
      end else if (pick < 80) begin
         ux = real'($urandom_range(2000)) - 1000.0;
         uy = real'($urandom_range(2000)) - 1000.0;
         uz = real'($urandom_range(2000)) - 1000.0;
         nrm = $sqrt(ux * ux + uy * uy + uz * uz);
         if (nrm < 1.0) begin
            ux = 1.0;
            nrm = 1.0;
         end
         rotate_by($rtoi(16384.0 * ux / nrm), $rtoi(16384.0 * uy / nrm),
                   $rtoi(16384.0 * uz / nrm), $urandom);
      end else if (pick < 90) begin
         rotate_by($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                   $urandom_range(4000) - 2000, $urandom);
      end else begin
         rotate_by($urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      sb = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = '0;
      idle_phase = 0;
      hold_cycles = 0;
      n_loads = 0;
      n_rotates = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: special angles, extremes, unused row, saturation
      rotate_by(0, 0, 16384, 0);
      rotate_by(0, 0, 16384, 16384);
      rotate_by(16384, 0, 0, -16384);
      rotate_by(0, 16384, 0, -32768);
      rotate_by(0, 0, 16384, 32767);
      rotate_by(0, 16384, 0, 16383);
      rotate_by(16384, 0, 0, -16385);
      rotate_by(0, 0, 0, 12345);
      load_row(3, 32767, -32768, 1);
      load_row(0, 32767, -32768, 0);
      load_row(1, -32768, 32767, -1);
      load_row(2, 16384, 16384, 32767);
      rotate_by(32767, 32767, 32767, 32767);
      rotate_by(-32768, -32768, -32768, -32768);
      rotate_by(-32768, 32767, -1, 8192);
      load_row(0, 16384, 0, 0);
      load_row(1, 0, 16384, 0);
      load_row(2, 0, 0, 16384);
      rotate_by(9459, 9459, 9459, 5461);
      rotate_by(-9459, 9459, -9459, -21845);

      for (int i = 0; i < RAND_BEATS; i++) begin
         if (i == RAND_BEATS / 3) idle_phase = 1;
         if (i == 2 * RAND_BEATS / 3) begin
            idle_phase = 2;
            hold_cycles = 600;
         end
         if (i == RAND_BEATS / 2) begin
            @(negedge clock);
            req_tvalid = 0;
            while (sb.pending() != 0) @(posedge clock);
         end
         if (i % 60 == 0) begin
            load_row(0, 16384, 0, 0);
            load_row(1, 0, 16384, 0);
            load_row(2, 0, 0, 16384);
         end
         random_beat();
      end
      @(negedge clock);
      req_tvalid = 0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("covered %0d row loads and %0d rotations, %0d matrices matched",
               n_loads, n_rotates, sb.matched);
      $display("idle mixes: sender-light/receiver-heavy, swapped, none; one long output stall");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
